// ===== rtl/core/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debounce / long press block
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int TICK_BITS_DEF = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_POLL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd3;

	// register reset values
	localparam logic [CFG_W-1:0] IDLE_POLL_RST  = 16'd10;
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd200;

	// event codes
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_PRESS  = 2'd1;
	localparam logic [1:0] EV_LONG   = 2'd2;
	localparam logic [1:0] EV_REPEAT = 2'd3;

	// reported state codes
	localparam logic [1:0] CODE_IDLE     = 2'd0;
	localparam logic [1:0] CODE_DEBOUNCE = 2'd1;
	localparam logic [1:0] CODE_PRESSED  = 2'd2;
	localparam logic [1:0] CODE_REPEAT   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_DEBOUNCE = 4'b0010,
		ST_PRESSED  = 4'b0100,
		ST_REPEAT   = 4'b1000
	} bdlp_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] idle_poll_period;
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] long_press_time;
		logic [CFG_W-1:0] repeat_period;
	} bdlp_cfg_t;

	function automatic logic [1:0] state_code(bdlp_state_t s);
		logic [1:0] c;
		unique case (s)
			ST_IDLE:     c = CODE_IDLE;
			ST_DEBOUNCE: c = CODE_DEBOUNCE;
			ST_PRESSED:  c = CODE_PRESSED;
			ST_REPEAT:   c = CODE_REPEAT;
			default:     c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/bdlp_fsm.sv =====
// ----------------------------------------------------------------------------
// bdlp_fsm
// button state machine and saturating tick counter, one step per tick
// ----------------------------------------------------------------------------
module bdlp_fsm import bdlp_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       pin,
	input  bdlp_cfg_t  cfg,
	output logic [1:0] ev_code,
	output logic [1:0] st_code
);

	localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

	bdlp_state_t          state_q, state_d;
	logic [TICK_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [CMP_W-1:0]     cnt_x;
	logic [CFG_W-1:0]     period;
	logic                 met;

	// saturating increment
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign cnt_x       = CMP_W'(elapsed_inc);

	always_comb begin
		unique case (state_q)
			ST_IDLE:     period = cfg.idle_poll_period;
			ST_DEBOUNCE: period = cfg.debounce_time;
			ST_PRESSED:  period = cfg.long_press_time;
			ST_REPEAT:   period = cfg.repeat_period;
			default:     period = cfg.idle_poll_period;
		endcase
	end

	assign met = (cnt_x >= CMP_W'(period));

	always_comb begin
		state_d   = state_q;
		elapsed_d = elapsed_inc;
		ev_code   = EV_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (met) begin
					state_d   = pin ? ST_DEBOUNCE : ST_IDLE;
					elapsed_d = '0;
				end
			end
			ST_DEBOUNCE: begin
				if (!pin) begin
					state_d = ST_IDLE;
				end else if (met) begin
					ev_code   = EV_PRESS;
					state_d   = ST_PRESSED;
					elapsed_d = '0;
				end
			end
			ST_PRESSED: begin
				if (!pin) begin
					state_d = ST_IDLE;
				end else if (met) begin
					ev_code   = EV_LONG;
					state_d   = ST_REPEAT;
					elapsed_d = '0;
				end
			end
			ST_REPEAT: begin
				if (!pin) begin
					state_d = ST_IDLE;
				end else if (met) begin
					ev_code   = EV_REPEAT;
					elapsed_d = '0;
				end
			end
			default: begin
				state_d   = ST_IDLE;
				elapsed_d = '0;
			end
		endcase
	end

	assign st_code = state_code(state_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			elapsed_q <= '0;
		end else if (step) begin
			state_q   <= state_d;
			elapsed_q <= elapsed_d;
		end
	end

	// every event restarts the count
	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ev_code != EV_NONE) |=> elapsed_q == '0)
		else $error("event without count restart");

	// a press always lands in the pressed state
	a_press_state: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ev_code == EV_PRESS) |=> state_q == ST_PRESSED)
		else $error("press event without pressed state");

	// nothing moves without a tick
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(state_q) && $stable(elapsed_q))
		else $error("state changed without a tick");

endmodule

// ===== rtl/core/button_debounce_long_press_repeat.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// debounced button with press, long press and auto-repeat events
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying the sampled pin level, and each
// produces exactly one result transaction holding the event of that tick
// (none, press, long press, repeat) and the state after it. One transaction
// is taken per clock cycle when the output side keeps up. A tick passes
// through the input register, then through the state update into the
// result register. The state update is a single compare of the tick
// count against the period of the current state. out_stall reaches in_stall
// only when both the input register and the result register are full.
// Configuration registers take effect immediately and should be written
// only while no transaction is in flight.
module button_debounce_long_press_repeat import bdlp_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pin_level,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           event_code,
	output logic [1:0]           machine_state,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	bdlp_cfg_t  cfg_q;
	logic       valid_s1, pin_s1;
	logic       out_valid_q;
	logic [1:0] event_q, state_code_q;
	logic       advance, step;
	logic [1:0] ev_code, st_code;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_poll_period <= IDLE_POLL_RST;
			cfg_q.debounce_time    <= DEBOUNCE_RST;
			cfg_q.long_press_time  <= LONG_PRESS_RST;
			cfg_q.repeat_period    <= REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDLE_POLL:  cfg_q.idle_poll_period <= cfg_data;
				CFG_DEBOUNCE:   cfg_q.debounce_time    <= cfg_data;
				CFG_LONG_PRESS: cfg_q.long_press_time  <= cfg_data;
				CFG_REPEAT:     cfg_q.repeat_period    <= cfg_data;
				default:        ;
			endcase
		end
	end

	// result register frees up when empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1 <= pin_level;
		end
	end

	bdlp_fsm #(
		.TICK_BITS(TICK_BITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.pin     (pin_s1),
		.cfg     (cfg_q),
		.ev_code (ev_code),
		.st_code (st_code)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q      <= ev_code;
			state_code_q <= st_code;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_code    = event_q;
	assign machine_state = state_code_q;

	// an accepted tick always lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transaction lost");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the button debounce / long press / repeat block
// ----------------------------------------------------------------------------
// Every accepted tick is run through a cycle-free model of the button machine
// and the expected event and state are queued. Each result transaction is
// checked against the head of that queue. The run starts with a short scripted
// walk through each event and configuration extreme. After that come
// randomised phases of presses, releases and glitches under freshly written
// periods. Both channels idle in random bursts, apart from the closing phases.
// ----------------------------------------------------------------------------
module tb;
	import bdlp_pkg::*;

	localparam int TB_TICK_BITS = TICK_BITS_DEF;

	// spare register indexes, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_REPEAT + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = '1;

	localparam int DRAIN_SETTLE  = 4;      // margin after the last result is back
	localparam int END_SETTLE    = 8;
	localparam int QUIET_LIMIT   = 1000;   // cycles with no transaction on either side
	localparam int HOLD_OFF_LEN  = 40;     // long output stall that backs up the input
	localparam int PHASES        = 12;
	localparam int PHASE_TICKS   = 72;
	localparam int HOLD_PHASE    = 2;
	localparam int SPAN_CAP      = 300;    // longest random press worth generating
	localparam int MAX_REPORTS   = 50;

	typedef struct packed {
		logic [1:0] ev;
		logic [1:0] st;
	} tick_report_t;

	typedef enum logic {
		ROW_TICK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             lvl;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0] data;
		logic             typed;
		logic [1:0]       ev;
		logic [1:0]       st;
	} script_row_t;

	// scripted opening: typed results only where they are obvious
	localparam int SCRIPT_ROWS = 34;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		// just out of reset, first tick is far from the poll period
		'{ROW_TICK, 1'b0, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_NONE,   CODE_IDLE},
		// all periods zero: every compare is met on every tick
		'{ROW_CFG,  1'b0, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_DEBOUNCE,   16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_LONG_PRESS, 16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_REPEAT,     16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_NONE,   CODE_DEBOUNCE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_PRESS,  CODE_PRESSED},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_LONG,   CODE_REPEAT},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_REPEAT, CODE_REPEAT},
		// release keeps the count, then an idle poll on a low pin
		'{ROW_TICK, 1'b0, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b0, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_NONE,   CODE_IDLE},
		// write to a spare index, must leave every period alone
		'{ROW_CFG,  1'b0, CFG_IDX_LAST,   16'hffff, 1'b0, EV_NONE,   CODE_IDLE},
		// short periods, full press / long press / repeat walk
		'{ROW_CFG,  1'b0, CFG_IDLE_POLL,  16'h0003, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_DEBOUNCE,   16'h0002, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_LONG_PRESS, 16'h0004, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_REPEAT,     16'h0002, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b0, CFG_IDLE_POLL,  16'h0000, 1'b0, EV_NONE,   CODE_IDLE},
		// all periods at their top value: nothing can happen for a long while
		'{ROW_CFG,  1'b0, CFG_IDLE_POLL,  16'hffff, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_DEBOUNCE,   16'hffff, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_LONG_PRESS, 16'hffff, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_CFG,  1'b0, CFG_REPEAT,     16'hffff, 1'b0, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_NONE,   CODE_IDLE},
		'{ROW_TICK, 1'b1, CFG_IDLE_POLL,  16'h0000, 1'b1, EV_NONE,   CODE_IDLE}
	};

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	// block inputs, all known from time zero
	logic                 in_valid  = 1'b0;
	logic                 pin_level = 1'b0;
	logic                 out_stall = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IDLE_POLL;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// block outputs
	logic       in_stall;
	logic       out_valid;
	logic [1:0] event_code;
	logic [1:0] machine_state;

	// typed expectation travelling alongside a scripted tick
	logic       tick_typed = 1'b0;
	logic [1:0] tick_ev    = EV_NONE;
	logic [1:0] tick_st    = CODE_IDLE;

	// shadow of the button machine and its periods
	bdlp_cfg_t                period_mirror = '{IDLE_POLL_RST, DEBOUNCE_RST,
	                                            LONG_PRESS_RST, REPEAT_RST};
	logic [1:0]               button_state  = CODE_IDLE;
	logic [TB_TICK_BITS-1:0]  button_ticks  = '0;

	tick_report_t expected_reports [$];

	// traffic shaping, set by the sequencer
	bit tx_gaps      = 1'b1;
	bit rx_gaps      = 1'b1;
	bit hold_off_req = 1'b0;

	// tallies
	int unsigned fail_count   = 0;
	int unsigned ticks_sent   = 0;
	int unsigned reports_seen = 0;
	int unsigned stall_cycles = 0;
	int unsigned hold_offs    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned event_tally [4] = '{0, 0, 0, 0};

	button_debounce_long_press_repeat #(
		.TICK_BITS(TB_TICK_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pin_level    (pin_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.machine_state(machine_state),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// one tick of the button machine: saturating count, then the state compare
	function automatic tick_report_t advance_button(input logic lvl);
		tick_report_t r;
		r.ev = EV_NONE;
		if (button_ticks != '1)
			button_ticks = button_ticks + 1'b1;
		case (button_state)
			CODE_IDLE: begin
				// poll point, a low pin simply restarts the wait
				if (button_ticks >= period_mirror.idle_poll_period) begin
					button_state = lvl ? CODE_DEBOUNCE : CODE_IDLE;
					button_ticks = '0;
				end
			end
			CODE_DEBOUNCE: begin
				if (!lvl) begin
					button_state = CODE_IDLE;
				end else if (button_ticks >= period_mirror.debounce_time) begin
					r.ev         = EV_PRESS;
					button_state = CODE_PRESSED;
					button_ticks = '0;
				end
			end
			CODE_PRESSED: begin
				if (!lvl) begin
					button_state = CODE_IDLE;
				end else if (button_ticks >= period_mirror.long_press_time) begin
					r.ev         = EV_LONG;
					button_state = CODE_REPEAT;
					button_ticks = '0;
				end
			end
			default: begin
				if (!lvl) begin
					button_state = CODE_IDLE;
				end else if (button_ticks >= period_mirror.repeat_period) begin
					r.ev         = EV_REPEAT;
					button_ticks = '0;
				end
			end
		endcase
		// note: leaving a state on a low pin keeps the count on purpose
		r.st = button_state;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [1:0] got,
			input logic [1:0] want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s got %0d, wanted %0d", $time, what, got, want);
	endtask

	// edge monitor: register mirror, tick prediction and result checks
	always @(posedge clk) begin
		tick_report_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IDLE_POLL:  period_mirror.idle_poll_period = cfg_data;
					CFG_DEBOUNCE:   period_mirror.debounce_time    = cfg_data;
					CFG_LONG_PRESS: period_mirror.long_press_time  = cfg_data;
					CFG_REPEAT:     period_mirror.repeat_period    = cfg_data;
					default: ;
				endcase
			end
			// queue before checking so a result arriving with its own tick would still line up
			if (in_valid && !in_stall) begin
				want = advance_button(pin_level);
				if (tick_typed) begin
					want.ev = tick_ev;
					want.st = tick_st;
				end
				expected_reports.push_back(want);
			end
			if (in_valid && in_stall)
				stall_cycles++;
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("result with nothing outstanding, event", event_code,
						EV_NONE);
				end else begin
					want = expected_reports.pop_front();
					if (event_code !== want.ev)
						report_mismatch("event_code", event_code, want.ev);
					if (machine_state !== want.st)
						report_mismatch("machine_state", machine_state, want.st);
					reports_seen++;
					event_tally[want.ev]++;
				end
			end
		end
	end

	// watchdog on transaction progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
					$display("button_debounce_long_press_repeat regression: fail");
					$finish;
				end
			end
		end
	end

	// result side: random stall bursts and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_LEN) @(posedge clk);
				out_stall    <= 1'b0;
				hold_off_req = 1'b0;
				hold_offs++;
			end else if (rx_gaps && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// offer one tick and hold it until taken, maybe idle afterwards
	task automatic send_tick(input logic lvl, input logic typed = 1'b0,
			input logic [1:0] ev = EV_NONE, input logic [1:0] st = CODE_IDLE);
		pin_level  <= lvl;
		tick_typed <= typed;
		tick_ev    <= ev;
		tick_st    <= st;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticks_sent++;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// stop sending and wait until every outstanding result is back; the first
	// edge lets the monitor queue the last accepted tick
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	// one register write, with cfg_we dropped again before returning so writes never run back to back
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly short periods so events happen, sometimes zero, wide or top value
	function automatic logic [CFG_W-1:0] pick_period();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll <= 5)
			return CFG_W'($urandom_range(0, 8));
		if (roll <= 7)
			return CFG_W'($urandom_range(9, 40));
		if (roll == 8)
			return CFG_W'($urandom);
		return '1;
	endfunction

	// presses of random length with releases in between, plus glitch bursts;
	// the last press of a phase is cut so the phase sends exactly n ticks
	task automatic press_sequence(input int unsigned n);
		int unsigned done_n, span, hold, rel, rel_top, left;
		done_n = 0;
		while (done_n < n) begin
			left = n - done_n;
			span = int'(period_mirror.idle_poll_period) + int'(period_mirror.debounce_time)
				+ int'(period_mirror.long_press_time) + 3 * int'(period_mirror.repeat_period) + 4;
			if (span > SPAN_CAP)
				span = SPAN_CAP;
			rel_top = (period_mirror.idle_poll_period > 20) ? 23
				: int'(period_mirror.idle_poll_period) + 3;
			if ($urandom_range(0, 4) == 0) begin
				// contact bounce: random levels
				hold = $urandom_range(1, 6);
				if (hold > left)
					hold = left;
				repeat (hold) send_tick(1'($urandom_range(0, 1)));
				done_n += hold;
			end else begin
				hold = $urandom_range(1, span);
				rel  = $urandom_range(1, rel_top);
				if (hold > left)
					hold = left;
				if (rel > left - hold)
					rel = left - hold;
				repeat (hold) send_tick(1'b1);
				repeat (rel) send_tick(1'b0);
				done_n += hold + rel;
			end
		end
	endtask

	// sequencer
	initial begin
		int unsigned r, ph;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted opening
		for (r = 0; r < SCRIPT_ROWS; r++) begin
			if (SCRIPT[r].kind == ROW_CFG) begin
				drain_block();
				cfg_write(SCRIPT[r].idx, SCRIPT[r].data);
			end else begin
				send_tick(SCRIPT[r].lvl, SCRIPT[r].typed, SCRIPT[r].ev, SCRIPT[r].st);
			end
		end

		// random phases, each under freshly written periods; the drain at the
		// head of each phase is also the pause until everything has come back
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph >= PHASES - 2) begin
				// closing stretch runs flat out
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else begin
				tx_gaps = $urandom_range(0, 3) != 0;
				rx_gaps = $urandom_range(0, 3) != 0;
			end
			drain_block();
			cfg_write(CFG_IDLE_POLL, pick_period());
			cfg_write(CFG_DEBOUNCE, pick_period());
			cfg_write(CFG_LONG_PRESS, pick_period());
			cfg_write(CFG_REPEAT, pick_period());
			if ($urandom_range(0, 2) == 0)
				cfg_write(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_LAST)),
					CFG_W'($urandom));
			if (ph == HOLD_PHASE)
				hold_off_req = 1'b1;
			press_sequence(PHASE_TICKS);
		end

		// wind down
		drain_block();
		repeat (END_SETTLE) @(posedge clk);

		$display("covered %0d ticks, %0d results checked: %0d press, %0d long press, %0d repeat",
			ticks_sent, reports_seen, event_tally[EV_PRESS], event_tally[EV_LONG],
			event_tally[EV_REPEAT]);
		$display("input held back on %0d cycles, %0d long output hold-off, %0d mismatches",
			stall_cycles, hold_offs, fail_count);
		if (fail_count == 0)
			$display("button_debounce_long_press_repeat regression: pass");
		else
			$display("button_debounce_long_press_repeat regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_fsm.sv
rtl/core/button_debounce_long_press_repeat.sv
test/tb.sv
